// File: sv/glw_pkg.sv
// Shared types and constants for the grid line tile walker.
// No dependencies; imported by grid_line_tile_walker_top.
`timescale 1ns / 1ps
`default_nettype none

package glw_pkg;

    localparam int COORD_W = 16;
    // Error term stays within +/- 2^17 for 16-bit endpoints.
    localparam int ERR_W   = 20;
    localparam int IN_W    = 4 * COORD_W;
    localparam int OUT_W   = 2 * COORD_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ERR_W-1:0]   t_err;

    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } t_mode;

endpackage

`default_nettype wire

// File: sv/grid_line_tile_walker_top.sv
// Grid line tile walker: walks the tiles crossed by a line between tile centers.
// Depends on glw_pkg (types, field widths, mode codes).
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake               Payload
// s        in   i_s_tvalid/o_s_tready   tdata {to_y,to_x,from_y,from_x}, tuser mode
// m        out  o_m_tvalid/i_m_tready   tdata {tile_y,tile_x}, tuser more
//
// A transfer on s updates the walk state and loads the result register in the
// same edge; the result shows on m the next cycle.
// Throughput is one item per clock while m does not stall, set by the single
// error-term update (add/compare on a 20-bit register) rather than any multiplier.
// o_s_tready is high whenever the result register is empty or being taken,
// so a stall on m holds s off only while a result is waiting.
// Reset (i_rst_n low, synchronous) clears the walk, the current tile and the m valid flag.
//
// The slope test adx*(2b+1) - ady*(2a+1) is kept as a running error term:
// it starts at adx - ady, drops by 2*ady on each x step and rises by 2*adx on
// each y step, so its sign picks x, y, or both at an exact corner.

module grid_line_tile_walker_top
    import glw_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  wire  [IN_W-1:0]    i_s_tdata,   // from_x, from_y, to_x, to_y
    input  wire                i_s_tuser,   // mode
    output logic               o_m_tvalid,
    input  wire                i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata,   // tile_x, tile_y
    output logic               o_m_tuser    // more
);

    // Walk state
    t_coord                r_cur_x, r_cur_y;
    t_coord                r_tgt_x, r_tgt_y;
    logic                  r_walking;
    logic                  r_neg_x, r_neg_y;      // step direction is -1
    logic                  r_dx_zero, r_dy_zero;  // axis-aligned line
    logic [COORD_W:0]      r_two_adx, r_two_ady;
    t_err                  r_err;

    // Result register
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_more;

    t_coord                n_cur_x, n_cur_y;
    logic                  n_walking;
    t_err                  n_err;

    logic                  s_accept;
    t_mode                 in_mode;
    t_coord                in_from_x, in_from_y, in_to_x, in_to_y;
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W-1:0]    adx, ady;
    logic                  step_x, step_y;

    assign in_mode   = t_mode'(i_s_tuser);
    assign in_from_x = i_s_tdata[COORD_W-1:0];
    assign in_from_y = i_s_tdata[2*COORD_W-1:COORD_W];
    assign in_to_x   = i_s_tdata[3*COORD_W-1:2*COORD_W];
    assign in_to_y   = i_s_tdata[4*COORD_W-1:3*COORD_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Start path: deltas and magnitudes
    always_comb begin
        dx  = {in_to_x[COORD_W-1], in_to_x} - {in_from_x[COORD_W-1], in_from_x};
        dy  = {in_to_y[COORD_W-1], in_to_y} - {in_from_y[COORD_W-1], in_from_y};
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    end

    // Advance path: step choice
    always_comb begin
        step_x = r_dy_zero || (!r_dx_zero && !r_err[ERR_W-1]);
        step_y = r_dx_zero || (!r_dy_zero && (r_err[ERR_W-1] || r_err == '0));
    end

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_walking = r_walking;
        n_err     = r_err;
        case (in_mode)
            MODE_START: begin
                n_cur_x   = in_from_x;
                n_cur_y   = in_from_y;
                n_walking = (in_from_x != in_to_x) || (in_from_y != in_to_y);
                n_err     = t_err'({1'b0, adx}) - t_err'({1'b0, ady});
            end
            MODE_ADVANCE: begin
                if (r_walking) begin
                    if (step_x) begin
                        n_cur_x = r_neg_x ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (!r_dx_zero && !r_dy_zero) begin
                        n_err = r_err
                              - (step_x ? t_err'(r_two_ady) : t_err'(0))
                              + (step_y ? t_err'(r_two_adx) : t_err'(0));
                    end
                    if (step_y) begin
                        n_cur_y = r_neg_y ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                    n_walking = (n_cur_x != r_tgt_x) || (n_cur_y != r_tgt_y);
                end
            end
            default: begin
                n_walking = r_walking;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_walking   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_cur_x   <= n_cur_x;
                r_cur_y   <= n_cur_y;
                r_walking <= n_walking;
            end
            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line parameters, error term and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_err      <= n_err;
            r_out_data <= {n_cur_y, n_cur_x};
            r_out_more <= n_walking;
            if (in_mode == MODE_START) begin
                r_tgt_x   <= in_to_x;
                r_tgt_y   <= in_to_y;
                r_neg_x   <= dx[COORD_W];
                r_neg_y   <= dy[COORD_W];
                r_dx_zero <= (dx == '0);
                r_dy_zero <= (dy == '0);
                r_two_adx <= {adx, 1'b0};
                r_two_ady <= {ady, 1'b0};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_more;

    // An active walk always has its current tile short of the target.
    a_walk_not_at_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walking |-> (r_cur_x != r_tgt_x) || (r_cur_y != r_tgt_y))
        else $error("walk active on target tile");

    // The reported more flag matches the walk state left by that item.
    a_more_tracks_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_m_tuser == r_walking)
        else $error("more flag disagrees with walk state");

    // An advance on an active walk moves the tile.
    a_advance_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_mode == MODE_ADVANCE && r_walking
        |=> (r_cur_x != $past(r_cur_x)) || (r_cur_y != $past(r_cur_y)))
        else $error("advance did not move the tile");

    // An advance with no walk leaves the tile where it was.
    a_idle_advance_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_mode == MODE_ADVANCE && !r_walking
        |=> $stable(r_cur_x) && $stable(r_cur_y) && !o_m_tuser)
        else $error("idle advance changed state");

endmodule

`default_nettype wire

// File: tb/grid_line_tile_walker_top_test.sv
// Self-checking testbench for grid_line_tile_walker_top: directed and random line walks.
// Depends on glw_pkg and the top level; a scoreboard class predicts every tile.
`timescale 1ns / 1ps

import glw_pkg::*;

typedef struct packed {
    t_coord tile_x;
    t_coord tile_y;
    logic   more;
} t_tile_result;

// Tracks the walk state and holds the tiles still due on the m side.
class tile_walk_scoreboard;
    t_coord       cur_x, cur_y, org_x, org_y, tgt_x, tgt_y;
    bit           walking;
    t_tile_result expected_tiles[$];
    int           failures;
    int           reported;

    function new();
        cur_x    = '0;
        cur_y    = '0;
        org_x    = '0;
        org_y    = '0;
        tgt_x    = '0;
        tgt_y    = '0;
        walking  = 1'b0;
        failures = 0;
        reported = 0;
    endfunction

    function int pending();
        return expected_tiles.size();
    endfunction

    // Steps the walk for one accepted input transfer and queues its tile.
    function void note_input(t_mode mode, logic [IN_W-1:0] data);
        longint       dx, dy, sx, sy, adx, ady, a, b, s;
        t_tile_result r;
        if (mode == MODE_START) begin
            org_x   = data[COORD_W-1:0];
            org_y   = data[2*COORD_W-1:COORD_W];
            tgt_x   = data[3*COORD_W-1:2*COORD_W];
            tgt_y   = data[4*COORD_W-1:3*COORD_W];
            cur_x   = org_x;
            cur_y   = org_y;
            walking = (org_x != tgt_x) || (org_y != tgt_y);
        end else if (walking) begin
            dx  = longint'(tgt_x) - longint'(org_x);
            dy  = longint'(tgt_y) - longint'(org_y);
            sx  = (dx < 0) ? -1 : 1;
            sy  = (dy < 0) ? -1 : 1;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            if (dx == 0) begin
                cur_y = t_coord'(longint'(cur_y) + sy);
            end else if (dy == 0) begin
                cur_x = t_coord'(longint'(cur_x) + sx);
            end else begin
                // doubled coordinates: borders sit at odd offsets from the centers
                a = (longint'(cur_x) - longint'(org_x)) * sx;
                b = (longint'(cur_y) - longint'(org_y)) * sy;
                s = adx * (2 * b + 1) - ady * (2 * a + 1);
                if (s >= 0) cur_x = t_coord'(longint'(cur_x) + sx);
                if (s <= 0) cur_y = t_coord'(longint'(cur_y) + sy);
            end
            if (cur_x == tgt_x && cur_y == tgt_y) walking = 1'b0;
        end
        r.tile_x = cur_x;
        r.tile_y = cur_y;
        r.more   = walking;
        expected_tiles.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic more);
        t_tile_result want, got;
        got.tile_x = data[COORD_W-1:0];
        got.tile_y = data[2*COORD_W-1:COORD_W];
        got.more   = more;
        if (expected_tiles.size() == 0) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("unexpected tile x=%0d y=%0d more=%0b",
                         got.tile_x, got.tile_y, got.more);
            end
            return;
        end
        want = expected_tiles.pop_front();
        if (got.tile_x !== want.tile_x || got.tile_y !== want.tile_y ||
            got.more !== want.more) begin
            failures++;
            if (reported < 10) begin
                reported++;
                $display("tile mismatch: expected x=%0d y=%0d more=%0b, got x=%0d y=%0d more=%0b",
                         want.tile_x, want.tile_y, want.more,
                         got.tile_x, got.tile_y, got.more);
            end
        end
    endfunction
endclass

module grid_line_tile_walker_top_test;

    localparam int IDLE_LIMIT = 2000;   // cycles without any transfer before giving up
    localparam int ITEM_COUNT = 1200;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata  = '0;   // from_x, from_y, to_x, to_y
    logic              i_s_tuser  = 1'b0; // mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;         // tile_x, tile_y
    logic              o_m_tuser;         // more

    tile_walk_scoreboard sb = new();

    int  sent_items = 0;
    int  idle_cycles = 0;
    bit  snd_burst = 1'b0;   // sender runs back to back while set
    bit  rcv_burst = 1'b0;   // receiver never stalls while set

    grid_line_tile_walker_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: check the m side first, then note the s side, so the queue
    // order follows the block. Also the watchdog on transfer activity.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
        if (i_s_tvalid && o_s_tready)
            sb.note_input(t_mode'(i_s_tuser), i_s_tdata);
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall for a randomly drawn gap before each result, with stall-free stretches.
    initial begin
        int gap;
        forever begin
            if ($urandom_range(0, 39) == 0) rcv_burst = !rcv_burst;
            gap = rcv_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // One s-side transfer. tvalid stays high across back-to-back items and
    // drops only when a gap is drawn, so it never gets two updates per step.
    task automatic send_item(input t_mode mode, input logic [IN_W-1:0] data);
        int gap;
        if ($urandom_range(0, 39) == 0) snd_burst = !snd_burst;
        gap = snd_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
    endtask

    task automatic start_line(input int fx, input int fy, input int tx, input int ty);
        send_item(MODE_START, {16'(ty), 16'(tx), 16'(fy), 16'(fx)});
    endtask

    // Advance items carry random payload: the block must ignore it.
    task automatic advance_tiles(input int n);
        repeat (n) send_item(MODE_ADVANCE, {$urandom, $urandom});
    endtask

    // Sender holds off until every queued tile has come out.
    task automatic hold_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Short line at a random place in the plane, mostly walked to its end.
    task automatic short_walk();
        int fx, fy, ddx, ddy, tx, ty, span, n;
        fx  = rand_coord();
        fy  = rand_coord();
        ddx = int'($urandom_range(0, 24)) - 12;
        ddy = int'($urandom_range(0, 24)) - 12;
        tx  = fx + ddx;
        ty  = fy + ddy;
        if (tx > 32767 || tx < -32768) tx = fx - ddx;
        if (ty > 32767 || ty < -32768) ty = fy - ddy;
        span = (ddx < 0 ? -ddx : ddx) + (ddy < 0 ? -ddy : ddy);
        // the walk never needs more advances than the Manhattan span
        if ($urandom_range(0, 3) != 0)
            n = span + $urandom_range(0, 2);
        else
            n = $urandom_range(0, span);
        start_line(fx, fy, tx, ty);
        advance_tiles(n);
    endtask

    initial begin
        int pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // advance with no walk after reset
        advance_tiles(1);
        // zero length line, then advance on the ended walk
        start_line(5, -7, 5, -7);
        advance_tiles(1);
        // full-range diagonal: exact corner steps, largest products
        start_line(-32768, -32768, 32767, 32767);
        advance_tiles(3);
        // opposite extremes, interrupts the walk above
        start_line(32767, -32768, -32768, 32767);
        advance_tiles(2);
        // vertical line downward, reach target, one advance past the end
        start_line(3, 3, 3, 0);
        advance_tiles(4);
        // horizontal line to the right
        start_line(-2, 1, 2, 1);
        advance_tiles(4);
        // shallow general slope
        start_line(0, 0, 3, 1);
        advance_tiles(4);
        hold_until_drained();

        while (sent_items < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                short_walk();
            end else if (pick < 88) begin
                start_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                advance_tiles($urandom_range(0, 20));
            end else if (pick < 97) begin
                advance_tiles($urandom_range(1, 3));
            end else begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: grid_line_tile_walker_top.f
sv/glw_pkg.sv
sv/grid_line_tile_walker_top.sv
tb/grid_line_tile_walker_top_test.sv
